// ===== design/keyed_count_table_unit_defines.svh =====
// Assertion macros shared by the keyed count table RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef KEYED_COUNT_TABLE_UNIT_DEFINES_SVH
`define KEYED_COUNT_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define KCT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kct_pkg.sv =====
// Shared constants, types and helper functions of the keyed count table.
// No dependencies; the interfaces, the controller and the top refer to it by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package kct_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned COUNT_BITS = 24;

  localparam int unsigned IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned IN_KEY_W    = 16;
  localparam int unsigned QTY_W       = 16;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned OUT_COUNT_W = 24;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned QMAG_W      = QTY_W - 1;
  localparam int unsigned SUM_W       = ((COUNT_BITS > QMAG_W) ? COUNT_BITS : QMAG_W) + 1;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_BAD_KEY   = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_SATURATED = 3'd5
  } status_e;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] count;
    logic                   present;
    status_e                status;
  } result_t;

  function automatic logic [KEY_BITS-1:0] to_key(input logic [IN_KEY_W-1:0] tag);
    logic [63:0] w;
    w = 64'(tag);
    return w[KEY_BITS-1:0];
  endfunction

  function automatic logic [OUT_COUNT_W-1:0] to_out_count(input logic [COUNT_BITS-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[OUT_COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/kct_in_if.sv =====
// Input channel of the keyed count table: valid/ready plus one operation item.
// Depends on kct_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface kct_in_if;
  logic                               valid;
  logic                               ready;
  logic        [kct_pkg::OP_W-1:0]     operation;
  logic        [kct_pkg::IN_KEY_W-1:0] tag_key;
  logic signed [kct_pkg::QTY_W-1:0]    quantity;

  modport source (output valid, output operation, output tag_key, output quantity,
                  input ready);
  modport sink   (input valid, input operation, input tag_key, input quantity,
                  output ready);
endinterface

`default_nettype wire

// ===== design/kct_out_if.sv =====
// Result channel of the keyed count table: valid/ready plus one result item.
// Depends on kct_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface kct_out_if;
  logic                                valid;
  logic                                ready;
  logic [kct_pkg::OUT_COUNT_W-1:0]     count;
  logic                                present;
  logic [kct_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output count, output present, output status,
                  input ready);
  modport sink   (input valid, input count, input present, input status,
                  output ready);
endinterface

`default_nettype wire

// ===== design/kct_entry_ram.sv =====
// Generic simple dual-port RAM, one write and one read port, registered read data.
// No package dependency; holds the key/count entries of the table.
`timescale 1ns / 1ps
`default_nettype none

module kct_entry_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 40,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/kct_ctrl.sv =====
// Sequencer of the keyed count table: scans the entry RAM, holds the valid flags,
// computes the update and writes it back. Depends on kct_pkg, kct_in_if, the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_count_table_unit_defines.svh"

module kct_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  kct_in_if.sink                        in_i,
  output logic                          ram_we_o,
  output logic [kct_pkg::IDX_W-1:0]     ram_waddr_o,
  output kct_pkg::entry_t               ram_wdata_o,
  output logic                          ram_re_o,
  output logic [kct_pkg::IDX_W-1:0]     ram_raddr_o,
  input  kct_pkg::entry_t               ram_rdata_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output kct_pkg::result_t              res_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  localparam int unsigned IW = kct_pkg::IDX_W;
  localparam int unsigned CW = kct_pkg::COUNT_BITS;
  localparam int unsigned SW = kct_pkg::SUM_W;
  localparam logic [IW-1:0] LAST_IDX  = IW'(kct_pkg::ENTRIES - 1);
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  logic [1:0]                         state_q, state_d;
  logic [kct_pkg::OP_W-1:0]           op_q;
  logic [kct_pkg::KEY_BITS-1:0]       key_q;
  logic signed [kct_pkg::QTY_W-1:0]   qty_q;
  logic [IW-1:0]                      scan_idx_q;
  logic [IW-1:0]                      cmp_idx_q;
  logic                               cmp_vld_q;
  logic                               hit_q;
  logic [IW-1:0]                      hit_idx_q;
  logic [CW-1:0]                      hit_cnt_q;
  logic                               free_q;
  logic [IW-1:0]                      free_idx_q;
  logic [kct_pkg::ENTRIES-1:0]        valid_q;

  logic            in_fire;
  logic            exec_fire;
  logic            cmp_match;
  logic            cmp_free;
  logic            qpos;
  logic [SW-1:0]   q_ext;
  logic [SW-1:0]   base_ext;
  logic [SW-1:0]   sum_ext;
  logic [SW-1:0]   diff_ext;
  logic            upd_we;
  logic            valid_set;
  logic            valid_clr;
  logic [IW-1:0]   upd_idx;
  logic [CW-1:0]   upd_cnt;
  logic [CW-1:0]   cnt_full;
  logic            res_present;
  kct_pkg::status_e res_status;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign res_valid_o = (state_q == S_EXEC);
  assign exec_fire   = res_valid_o && res_ready_i;

  // Read one entry per scan cycle; the registered read data comes back in the next cycle.
  assign ram_re_o    = (state_q == S_SCAN);
  assign ram_raddr_o = scan_idx_q;

  assign cmp_match = cmp_vld_q && valid_q[cmp_idx_q] && (ram_rdata_i.key == key_q);
  assign cmp_free  = cmp_vld_q && !valid_q[cmp_idx_q];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      valid_q    <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == S_SCAN);
      if (in_fire) begin
        scan_idx_q <= '0;
        hit_q      <= 1'b0;
        free_q     <= 1'b0;
      end else if (state_q == S_SCAN) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
      if (cmp_match && !hit_q) begin
        hit_q <= 1'b1;
      end
      // Keep the lowest free slot.
      if (cmp_free && !free_q) begin
        free_q <= 1'b1;
      end
      if (exec_fire && valid_set) begin
        valid_q[upd_idx] <= 1'b1;
      end else if (exec_fire && valid_clr) begin
        valid_q[upd_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_i.operation;
      key_q <= kct_pkg::to_key(in_i.tag_key);
      qty_q <= in_i.quantity;
    end
    if (state_q == S_SCAN) begin
      cmp_idx_q <= scan_idx_q;
    end
    if (cmp_match && !hit_q) begin
      hit_idx_q <= cmp_idx_q;
      hit_cnt_q <= ram_rdata_i.count;
    end
    if (cmp_free && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  assign qpos     = (qty_q != '0) && !qty_q[kct_pkg::QTY_W-1];
  assign q_ext    = SW'(qty_q[kct_pkg::QMAG_W-1:0]);
  assign base_ext = hit_q ? SW'(hit_cnt_q) : '0;
  assign sum_ext  = base_ext + q_ext;
  assign diff_ext = base_ext - q_ext;

  always_comb begin
    upd_we      = 1'b0;
    valid_set   = 1'b0;
    valid_clr   = 1'b0;
    upd_idx     = hit_idx_q;
    upd_cnt     = hit_cnt_q;
    cnt_full    = '0;
    res_present = 1'b0;
    res_status  = kct_pkg::ST_DONE;
    if (key_q == '0) begin
      res_status = kct_pkg::ST_BAD_KEY;
    end else if (op_q != kct_pkg::OP_ADD && op_q != kct_pkg::OP_REMOVE) begin
      if (hit_q) begin
        cnt_full    = hit_cnt_q;
        res_present = 1'b1;
      end
    end else if (!qpos) begin
      res_status = kct_pkg::ST_IGNORED;
      if (hit_q) begin
        cnt_full    = hit_cnt_q;
        res_present = 1'b1;
      end
    end else if (op_q == kct_pkg::OP_ADD) begin
      if (!hit_q && !free_q) begin
        res_status = kct_pkg::ST_FULL;
      end else begin
        upd_we    = 1'b1;
        valid_set = 1'b1;
        upd_idx   = hit_q ? hit_idx_q : free_idx_q;
        if (sum_ext > SW'(COUNT_MAX)) begin
          upd_cnt    = COUNT_MAX;
          res_status = kct_pkg::ST_SATURATED;
        end else begin
          upd_cnt = sum_ext[CW-1:0];
        end
        cnt_full    = upd_cnt;
        res_present = 1'b1;
      end
    end else begin
      if (!hit_q) begin
        res_status = kct_pkg::ST_NOT_FOUND;
      end else if (base_ext <= q_ext) begin
        // Drop the entry once the count would fall below one.
        valid_clr = 1'b1;
      end else begin
        upd_we      = 1'b1;
        upd_cnt     = diff_ext[CW-1:0];
        cnt_full    = upd_cnt;
        res_present = 1'b1;
      end
    end
  end

  assign ram_we_o          = exec_fire && upd_we;
  assign ram_waddr_o       = upd_idx;
  assign ram_wdata_o.key   = key_q;
  assign ram_wdata_o.count = upd_cnt;

  assign res_o.count   = kct_pkg::to_out_count(cnt_full);
  assign res_o.present = res_present;
  assign res_o.status  = res_status;

  `KCT_ASSERT_IMPL(a_write_on_result, ram_we_o, res_valid_o && res_ready_i,
    "entry RAM written outside a delivered result")
  `KCT_ASSERT_IMPL(a_present_nonzero, res_valid_o && res_present, cnt_full != '0,
    "present result carries a zero count")
  `KCT_ASSERT_IMPL(a_free_slot_unused, free_q && (state_q == S_EXEC), !valid_q[free_idx_q],
    "recorded free slot is marked valid")
  `KCT_ASSERT_NEXT(a_alloc_marks_valid, exec_fire && valid_set, valid_q[$past(upd_idx)],
    "allocated entry not marked valid")
  `KCT_ASSERT_NEXT(a_scan_ends, (state_q == S_SCAN) && (scan_idx_q == LAST_IDX),
    state_q == S_DRAIN, "scan did not end after the last entry")

endmodule

`default_nettype wire

// ===== design/keyed_count_table_unit.sv =====
// Keyed count table: fully associative key/count store with add, remove and query.
// Flow: an accepted transaction passes a scan state that reads every entry in turn over
// the single RAM read port, a drain state, then an execute state that writes the update.
// A new item is taken only once the last result has entered the output register.
// Reset: valid flags clear at once, so the table is empty with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module keyed_count_table_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  kct_in_if.sink     in_i,
  kct_out_if.source  out_o
);

  logic                          ram_we;
  logic [kct_pkg::IDX_W-1:0]     ram_waddr;
  kct_pkg::entry_t               ram_wdata;
  logic                          ram_re;
  logic [kct_pkg::IDX_W-1:0]     ram_raddr;
  kct_pkg::entry_t               ram_rdata;
  logic                          res_valid;
  logic                          res_ready;
  kct_pkg::result_t              res;

  logic                          out_vld_q;
  kct_pkg::result_t              out_q;

  kct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  kct_entry_ram #(
    .DEPTH (kct_pkg::ENTRIES),
    .WIDTH ($bits(kct_pkg::entry_t)),
    .AW    (kct_pkg::IDX_W)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: take a new result when empty or when the current one leaves.
  assign res_ready = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.count   = out_q.count;
  assign out_o.present = out_q.present;
  assign out_o.status  = out_q.status;

endmodule

`default_nettype wire
